>>> rtl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the colormap sampler: map codes, polynomial
// coefficients in thousandths, coolwarm end colors and the divide-by-1000 step.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int COEF_W = 13;
    typedef logic signed [COEF_W-1:0] coef_t;

    localparam logic [2:0] MAP_GRAY     = 3'd0;
    localparam logic [2:0] MAP_VIRIDIS  = 3'd1;
    localparam logic [2:0] MAP_PLASMA   = 3'd2;
    localparam logic [2:0] MAP_COOLWARM = 3'd3;
    localparam logic [2:0] MAP_JET      = 3'd4;

    // [map: viridis, plasma][channel][c0..c3]
    localparam coef_t POLY_COEF [2][3][4] = '{
        '{ '{-13'sd19,   13'sd835,  -13'sd1334, 13'sd963},
           '{ 13'sd5,    13'sd1399, -13'sd979,  13'sd551},
           '{ 13'sd287,  13'sd1758, -13'sd3296, 13'sd1579} },
        '{ '{ 13'sd50,   13'sd2100, -13'sd2200, 13'sd1050},
           '{ 13'sd10,   13'sd50,    13'sd1500, -13'sd600},
           '{ 13'sd530,  13'sd800,  -13'sd1050, 13'sd0} }
    };

    localparam logic [7:0] CW_BLUE [3] = '{8'd59, 8'd76, 8'd192};
    localparam logic [7:0] CW_GREY [3] = '{8'd221, 8'd221, 8'd221};
    localparam logic [7:0] CW_RED  [3] = '{8'd180, 8'd4, 8'd38};

    // scaled channel before /1000, at most 255000
    localparam int Y_W = 18;
    // floor(y / 1000) == (y * DIV_MUL) >> DIV_SHIFT for y < 2^18
    localparam int DIV_MUL_W = 19;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 19'd268436;
    localparam int DIV_SHIFT = 28;
    localparam int DIV_PROD_W = Y_W + DIV_MUL_W;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

endpackage

>>> rtl/cms_horner.sv
// ----------------------------------------------------------------------------
// cms_horner
// Three-stage Horner evaluation of the viridis / plasma cubics, one lane per
// channel. Stage 1: c2 + c3*p, stages 2 and 3: c + floor(A*p / 2^F).
// ----------------------------------------------------------------------------
module cms_horner
    import cms_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    localparam int AW = FRACTION_BITS + 14,
    localparam int PW = AW + FRACTION_BITS + 2
) (
    input  logic                   aclk,
    input  pipe_en_t               en,
    input  logic [FRACTION_BITS:0] p_in,
    input  logic [2:0]             sel_in,
    output logic [FRACTION_BITS:0] p_out,
    output logic [2:0]             sel_out,
    output logic signed [AW-1:0]   a_out [3]
);

    localparam int F = FRACTION_BITS;

    logic [F:0]  p1_reg, p2_reg, p3_reg;
    logic [2:0]  sel1_reg, sel2_reg, sel3_reg;
    logic        mi0, mi1, mi2;

    assign mi0 = (sel_in == MAP_PLASMA);
    assign mi1 = (sel1_reg == MAP_PLASMA);
    assign mi2 = (sel2_reg == MAP_PLASMA);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            p1_reg   <= p_in;
            sel1_reg <= sel_in;
        end
        if (en.s2) begin
            p2_reg   <= p1_reg;
            sel2_reg <= sel1_reg;
        end
        if (en.s3) begin
            p3_reg   <= p2_reg;
            sel3_reg <= sel2_reg;
        end
    end

    assign p_out   = p3_reg;
    assign sel_out = sel3_reg;

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic signed [AW-1:0] a1_reg, a2_reg, a3_reg;
        logic signed [AW-1:0] a1_next, a2_next, a3_next;
        logic signed [AW-1:0] c3_ext, c2_ext, c1_ext, c0_ext;
        logic signed [AW-1:0] m1;
        logic signed [PW-1:0] m2, m3, sh2, sh3;
        logic signed [F+1:0]  p0_s, p1_s, p2_s;

        assign p0_s = $signed({1'b0, p_in});
        assign p1_s = $signed({1'b0, p1_reg});
        assign p2_s = $signed({1'b0, p2_reg});

        assign c3_ext = AW'(POLY_COEF[mi0][ch][3]);
        assign c2_ext = AW'(POLY_COEF[mi0][ch][2]);
        assign c1_ext = AW'(POLY_COEF[mi1][ch][1]);
        assign c0_ext = AW'(POLY_COEF[mi2][ch][0]);

        always_comb begin
            m1      = c3_ext * p0_s;
            a1_next = (c2_ext <<< F) + m1;
            m2      = a1_reg * p1_s;
            sh2     = m2 >>> F;
            a2_next = (c1_ext <<< F) + sh2[AW-1:0];
            m3      = a2_reg * p2_s;
            sh3     = m3 >>> F;
            a3_next = (c0_ext <<< F) + sh3[AW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en.s1) begin
                a1_reg <= a1_next;
            end
            if (en.s2) begin
                a2_reg <= a2_next;
            end
            if (en.s3) begin
                a3_reg <= a3_next;
            end
        end

        assign a_out[ch] = a3_reg;
    end

endmodule

>>> rtl/cms_scale.sv
// ----------------------------------------------------------------------------
// cms_scale
// Clamps each polynomial result to [0, 1000*2^F] and registers
// floor(A*255 / 2^F), ready for the final divide by 1000.
// ----------------------------------------------------------------------------
module cms_scale
    import cms_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    localparam int AW = FRACTION_BITS + 14
) (
    input  logic                 aclk,
    input  pipe_en_t             en,
    input  logic signed [AW-1:0] a_in [3],
    output logic [Y_W-1:0]       y_out [3]
);

    localparam int F  = FRACTION_BITS;
    localparam int AC = F + 10;
    localparam int XW = F + 18;
    localparam logic [AW-1:0] LIM = AW'(1000) << F;

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [AC-1:0]  ac;
        logic [XW-1:0]  xw;
        logic [Y_W-1:0] y_reg;

        always_comb begin
            if (a_in[ch][AW-1]) begin
                ac = '0;
            end else if ($unsigned(a_in[ch]) > LIM) begin
                ac = LIM[AC-1:0];
            end else begin
                ac = a_in[ch][AC-1:0];
            end
            xw = XW'({ac, 8'h00}) - XW'(ac);
        end

        always_ff @(posedge aclk) begin
            if (en.s4) begin
                y_reg <= xw[F +: Y_W];
            end
        end

        assign y_out[ch] = y_reg;
    end

endmodule

>>> rtl/cms_linear.sv
// ----------------------------------------------------------------------------
// cms_linear
// Piecewise-linear maps: grayscale, coolwarm two-segment blend and jet tents.
// Selector codes without a map give white. Result registered in stage 4.
// ----------------------------------------------------------------------------
module cms_linear
    import cms_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  pipe_en_t               en,
    input  logic [FRACTION_BITS:0] p_in,
    input  logic [2:0]             sel_in,
    output logic [7:0]             rgb_out [3]
);

    localparam int F  = FRACTION_BITS;
    localparam int JW = F + 4;
    localparam int GW = F + 9;
    localparam logic signed [JW-1:0] THREE_HALF = JW'(3) << (F - 1);
    localparam logic signed [JW-1:0] ONE_J      = JW'(1) << F;

    logic [GW-1:0] gray_t;
    logic [7:0]    gray;
    logic          lower;
    logic [F:0]    d_up;
    logic [F:0]    s;

    always_comb begin
        gray_t = GW'({p_in, 8'h00}) - GW'(p_in);
        gray   = gray_t[F +: 8];
        lower  = !p_in[F] && !p_in[F-1];
        d_up   = p_in - ((F+1)'(1) << (F - 1));
        s      = lower ? {p_in[F-1:0], 1'b0} : {d_up[F-1:0], 1'b0};
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        localparam logic [JW-1:0] KONE = JW'(3 - ch) << F;

        logic [7:0]           ca, cb;
        logic signed [9:0]    diff;
        logic signed [F+1:0]  s_s;
        logic signed [F+11:0] cw_prod, cw_sh;
        logic [9:0]           cw_sum;
        logic signed [JW-1:0] jd, jad, jv;
        logic [F:0]           jvc;
        logic [GW-1:0]        jt;
        logic [7:0]           sel_val;
        logic [7:0]           rgb_reg;

        always_comb begin
            ca      = lower ? CW_BLUE[ch] : CW_GREY[ch];
            cb      = lower ? CW_GREY[ch] : CW_RED[ch];
            diff    = $signed({2'b00, cb}) - $signed({2'b00, ca});
            s_s     = $signed({1'b0, s});
            cw_prod = diff * s_s;
            cw_sh   = cw_prod >>> F;
            cw_sum  = {2'b00, ca} + cw_sh[9:0];

            jd  = $signed(JW'({p_in, 2'b00})) - $signed(KONE);
            jad = jd[JW-1] ? -jd : jd;
            jv  = THREE_HALF - jad;
            if (jv[JW-1]) begin
                jvc = '0;
            end else if (jv > ONE_J) begin
                jvc = ONE_J[F:0];
            end else begin
                jvc = jv[F:0];
            end
            jt = GW'({jvc, 8'h00}) - GW'(jvc);

            case (sel_in)
                MAP_GRAY: begin
                    sel_val = gray;
                end
                MAP_COOLWARM: begin
                    sel_val = cw_sum[7:0];
                end
                MAP_JET: begin
                    sel_val = jt[F +: 8];
                end
                default: begin
                    sel_val = 8'hFF;
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (en.s4) begin
                rgb_reg <= sel_val;
            end
        end

        assign rgb_out[ch] = rgb_reg;
    end

endmodule

>>> rtl/colormap_sampler_top.sv
// ----------------------------------------------------------------------------
// colormap_sampler_top
// Maps a fixed-point position in [0, 1] to an 8-bit RGB color, one of five maps.
// ----------------------------------------------------------------------------
// Five-stage pipeline: an accepted input transaction is registered in stage 1
// and passes stages 2, 3 and 4 before stage 5 loads the output register that
// drives m_tdata and m_tvalid, and one transaction is taken every
// clock while the output side keeps up. Stages 1-3 are the Horner steps of the
// polynomial maps (one multiplier per channel per stage), stage 4 clamps and
// scales or evaluates the linear maps, stage 5 divides by 1000 and selects the
// map result. Each stage holds its own valid bit, so empty stages fill while
// the output waits and s_tready drops only when every stage is occupied.
// map_select is taken on a cfg_valid/cfg_ready transaction (cfg_ready is
// always high) and is expected to change only while the pipeline is empty.
module colormap_sampler_top
    import cms_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    localparam int S_TDATA_W = ((FRACTION_BITS + 8) / 8) * 8,
    localparam int AW = FRACTION_BITS + 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    localparam int F = FRACTION_BITS;

    logic [2:0]  map_sel_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    pipe_en_t    en;
    logic [F:0]  raw, p_sat, p3;
    logic [2:0]  sel3, sel4_reg;
    logic signed [AW-1:0] a3 [3];
    logic [Y_W-1:0]       y4 [3];
    logic [7:0]           lin4 [3];
    logic [23:0]          rgb_next, rgb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_sel_reg <= MAP_GRAY;
        end else if (cfg_valid && cfg_ready) begin
            map_sel_reg <= cfg_data;
        end
    end

    always_comb begin
        en.s5 = !v5_reg || m_tready;
        en.s4 = !v4_reg || en.s5;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign s_tready = en.s1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en.s1) v1_reg <= s_tvalid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
            if (en.s5) v5_reg <= v4_reg;
        end
    end

    // saturate above 1.0
    always_comb begin
        raw   = s_tdata[F:0];
        p_sat = (raw[F] && (|raw[F-1:0])) ? ((F+1)'(1) << F) : raw;
    end

    cms_horner #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_horner (
        .aclk   (aclk),
        .en     (en),
        .p_in   (p_sat),
        .sel_in (map_sel_reg),
        .p_out  (p3),
        .sel_out(sel3),
        .a_out  (a3)
    );

    cms_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .aclk (aclk),
        .en   (en),
        .a_in (a3),
        .y_out(y4)
    );

    cms_linear #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_linear (
        .aclk   (aclk),
        .en     (en),
        .p_in   (p3),
        .sel_in (sel3),
        .rgb_out(lin4)
    );

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            sel4_reg <= sel3;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_out
        logic [DIV_PROD_W-1:0] q_prod;

        always_comb begin
            q_prod = y4[ch] * DIV_MUL;
            if (sel4_reg == MAP_VIRIDIS || sel4_reg == MAP_PLASMA) begin
                rgb_next[ch*8 +: 8] = q_prod[DIV_SHIFT +: 8];
            end else begin
                rgb_next[ch*8 +: 8] = lin4[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_tdata = rgb_reg;

endmodule
